// ===== hw/rtl/dsbq_pkg.sv =====
// Shared types and constants for the dual shelf biquad cascade.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dsbq_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int QSHIFT      = 28;
    localparam int TAPS        = 5;
    localparam int COEFS       = 2 * TAPS;
    localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
    // five products of at most 2^54 in size plus the rounding term fit here
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int CFG_BITS    = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int TAP_W       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B0_B1      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B2_A1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_A2_HIGH_B0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B1_B2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_A1_A2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS         = 3'd5;

    // tap positions within one biquad
    localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << QSHIFT);
    localparam logic signed [ACC_BITS-1:0]  ACC_RND  = ACC_BITS'(1 << (QSHIFT - 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_RND,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             mul;
        logic             acc;
        logic             rnd;
        logic             commit;
        logic [TAP_W-1:0] tap;
        logic             stage;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bypass_now;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/dsbq_ctrl.sv =====
// Sequencer for the shared multiply-accumulate: two biquads of five taps each.
// Depends on dsbq_pkg for the state type and the command/status structs.
`default_nettype none

module dsbq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  dsbq_pkg::t_status i_status,
    output dsbq_pkg::t_cmd    o_cmd
);
    import dsbq_pkg::*;

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic             r_stage, n_stage;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= TAP_B0;
            r_stage <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_stage <= n_stage;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_stage = r_stage;
        unique case (r_state)
            S_IDLE: begin
                n_tap   = TAP_B0;
                n_stage = 1'b0;
                if (i_valid) begin
                    n_state = i_status.bypass_now ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_tap == TAP_A2) begin
                    n_state = S_ACC;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            S_ACC: begin
                n_state = S_RND;
            end
            S_RND: begin
                n_tap = TAP_B0;
                if (!r_stage) begin
                    n_stage = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.tap    = r_tap;
        o_cmd.stage  = r_stage;
        o_stall      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.acc = (r_tap != TAP_B0);
            end
            S_ACC:  o_cmd.acc    = 1'b1;
            S_RND:  o_cmd.rnd    = 1'b1;
            S_DONE: o_cmd.commit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dsbq_dp.sv =====
// Datapath: coefficient registers, per-channel history, one 32x24 multiplier,
// accumulator, round/saturate and the output register. Depends on dsbq_pkg.
`default_nettype none

module dsbq_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [dsbq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [dsbq_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  wire                                 i_channel,
    input  wire  signed [dsbq_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  dsbq_pkg::t_cmd                      i_cmd,
    output dsbq_pkg::t_status                   o_status,
    input  wire                                 i_stall,
    output logic                                o_valid,
    output logic                                o_channel_out,
    output logic signed [dsbq_pkg::SAMPLE_BITS-1:0] o_sample_out
);
    import dsbq_pkg::*;

    localparam int SHR_BITS = ACC_BITS - QSHIFT;
    localparam logic signed [SHR_BITS-1:0] S_MAX = SHR_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SHR_BITS-1:0] S_MIN = -S_MAX - SHR_BITS'(1);

    logic signed [COEF_BITS-1:0]   r_coef [COEFS];
    logic                          r_bypass;
    logic signed [SAMPLE_BITS-1:0] r_lin  [CHANNELS][2];
    logic signed [SAMPLE_BITS-1:0] r_lout [CHANNELS][2];
    logic signed [SAMPLE_BITS-1:0] r_hout [CHANNELS][2];
    logic                          r_ch;
    logic                          r_byp;
    logic signed [SAMPLE_BITS-1:0] r_x, r_mid, r_y;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic                          r_sub;
    logic signed [ACC_BITS-1:0]    r_acc;

    logic [3:0]                    coef_idx;
    logic signed [COEF_BITS-1:0]   coef_sel;
    logic signed [SAMPLE_BITS-1:0] opnd;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [SHR_BITS-1:0]    shr;
    logic signed [SAMPLE_BITS-1:0] rnd_sat;

    // coefficient and bypass registers; two coefficients per write, upper first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // unity b0 on both shelves, everything else zero
            for (int i = 0; i < COEFS; i++)
                r_coef[i] <= (i == 0 || i == TAPS) ? COEF_ONE : '0;
            r_bypass  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_BYPASS) begin
                r_bypass <= i_cfg_data[0];
            end else if (i_cfg_idx < REG_BYPASS) begin
                r_coef[{i_cfg_idx, 1'b0}] <= i_cfg_data[CFG_BITS-1:COEF_BITS];
                r_coef[{i_cfg_idx, 1'b1}] <= i_cfg_data[COEF_BITS-1:0];
            end
        end
    end

    assign o_status.bypass_now = r_bypass || (32'(i_channel) >= CHANNELS);
    assign o_status.out_free   = !o_valid || !i_stall;

    // operand selection for the current stage and tap
    assign coef_idx = (i_cmd.stage ? 4'(TAPS) : 4'd0) + 4'(i_cmd.tap);
    assign coef_sel = r_coef[coef_idx];

    always_comb begin
        unique case (i_cmd.tap)
            TAP_B0:  opnd = i_cmd.stage ? r_mid : r_x;
            TAP_B1:  opnd = i_cmd.stage ? r_lout[r_ch][0] : r_lin[r_ch][0];
            TAP_B2:  opnd = i_cmd.stage ? r_lout[r_ch][1] : r_lin[r_ch][1];
            TAP_A1:  opnd = i_cmd.stage ? r_hout[r_ch][0] : r_lout[r_ch][0];
            TAP_A2:  opnd = i_cmd.stage ? r_hout[r_ch][1] : r_lout[r_ch][1];
            default: opnd = '0;
        endcase
    end

    assign prod_ext = {{(ACC_BITS - PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};

    // floor shift, then clamp to the sample range
    assign shr = r_acc[ACC_BITS-1:QSHIFT];
    always_comb begin
        priority if (shr > S_MAX) rnd_sat = S_MAX[SAMPLE_BITS-1:0];
        else if (shr < S_MIN)     rnd_sat = S_MIN[SAMPLE_BITS-1:0];
        else                      rnd_sat = shr[SAMPLE_BITS-1:0];
    end

    // input capture, multiply, accumulate, round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_channel;
            r_byp <= o_status.bypass_now;
            r_x   <= i_sample_in;
        end
        if (i_cmd.mul) begin
            r_prod <= coef_sel * opnd;
            r_sub  <= (i_cmd.tap == TAP_A1) || (i_cmd.tap == TAP_A2);
        end
        if (i_cmd.load || i_cmd.rnd) begin
            r_acc <= ACC_RND;
        end else if (i_cmd.acc) begin
            r_acc <= r_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
        if (i_cmd.rnd) begin
            if (i_cmd.stage) r_y   <= rnd_sat;
            else             r_mid <= rnd_sat;
        end
    end

    // history shift on a filtered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < 2; k++) begin
                    r_lin[c][k]  <= '0;
                    r_lout[c][k] <= '0;
                    r_hout[c][k] <= '0;
                end
            end
        end else if (i_cmd.commit && !r_byp) begin
            r_lin[r_ch][1]  <= r_lin[r_ch][0];
            r_lin[r_ch][0]  <= r_x;
            r_lout[r_ch][1] <= r_lout[r_ch][0];
            r_lout[r_ch][0] <= r_mid;
            r_hout[r_ch][1] <= r_hout[r_ch][0];
            r_hout[r_ch][0] <= r_y;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_channel_out <= r_ch;
            o_sample_out  <= r_byp ? r_x : r_y;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_shelf_biquad_cascade.sv =====
// Two-channel low-shelf then high-shelf biquad cascade, one shared multiplier.
// A filtered beat runs ten products through the one 32x24 multiplier, five per
// shelf (MUL, then ACC and RND); a bypassed beat goes straight to DONE. A new beat
// is taken only once the result is committed to a free output register.
// Reset (synchronous, active low) clears history to zero, loads unity b0 for
// both shelves, clears bypass and empties the output register.
`default_nettype none

module dual_shelf_biquad_cascade (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_channel,
    input  wire  signed [dsbq_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_channel_out,
    output logic signed [dsbq_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  wire                                 i_cfg_we,
    input  wire  [dsbq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [dsbq_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import dsbq_pkg::*;

    t_cmd    cmd;
    t_status status;

    dsbq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dsbq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out)
    );

`ifndef ASSERT_OFF
    // an accepted beat holds off the next one in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a beat");

    // a result is only written into a free output register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // a commit always leaves a valid result behind
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_valid)
        else $error("committed result not presented");

    // the sequencer is idle again after the commit
    a_idle_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> !o_stall)
        else $error("input held off after result commit");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for dual_shelf_biquad_cascade: directed and random beats
// are checked against a cycle-free model of the two shelf stages.
// Needs dsbq_pkg and the cascade RTL only.
`timescale 1ns / 100ps

import dsbq_pkg::*;

// Expected-result tracker: mirrors coefficients, bypass and per-channel history
class shelf_eq_tracker;

    typedef struct {
        bit                            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_result_beat;

    // low shelf taps at 0..4, high shelf taps at TAPS..TAPS+4
    longint       coef [COEFS];
    bit           bypass_on;
    // index ch*2 is the newest entry, ch*2+1 the one before
    longint       in_hist  [CHANNELS * 2];
    longint       mid_hist [CHANNELS * 2];
    longint       out_hist [CHANNELS * 2];
    t_result_beat expected_q [$];
    int           errors;

    function new();
        foreach (coef[i]) coef[i] = 0;
        foreach (in_hist[i]) begin
            in_hist[i]  = 0;
            mid_hist[i] = 0;
            out_hist[i] = 0;
        end
        coef[TAP_B0]        = longint'(COEF_ONE);
        coef[TAPS + TAP_B0] = longint'(COEF_ONE);
        bypass_on = 1'b0;
        errors    = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // mirror of a register write; unused indexes are ignored
    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] data);
        case (idx)
            REG_LOW_B0_B1: begin
                coef[TAP_B0] = $signed(data[CFG_BITS-1:COEF_BITS]);
                coef[TAP_B1] = $signed(data[COEF_BITS-1:0]);
            end
            REG_LOW_B2_A1: begin
                coef[TAP_B2] = $signed(data[CFG_BITS-1:COEF_BITS]);
                coef[TAP_A1] = $signed(data[COEF_BITS-1:0]);
            end
            REG_LOW_A2_HIGH_B0: begin
                coef[TAP_A2]        = $signed(data[CFG_BITS-1:COEF_BITS]);
                coef[TAPS + TAP_B0] = $signed(data[COEF_BITS-1:0]);
            end
            REG_HIGH_B1_B2: begin
                coef[TAPS + TAP_B1] = $signed(data[CFG_BITS-1:COEF_BITS]);
                coef[TAPS + TAP_B2] = $signed(data[COEF_BITS-1:0]);
            end
            REG_HIGH_A1_A2: begin
                coef[TAPS + TAP_A1] = $signed(data[CFG_BITS-1:COEF_BITS]);
                coef[TAPS + TAP_A2] = $signed(data[COEF_BITS-1:0]);
            end
            REG_BYPASS: bypass_on = data[0];
            default: ;
        endcase
    endfunction

    // 64-bit add that clips at the signed limits
    function longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // one Direct Form I biquad: sum, round half up, floor shift, clip to sample range
    function longint run_stage(int base, longint x, longint x1, longint x2,
                               longint y1, longint y2);
        longint acc;
        longint top;
        acc = coef[base + TAP_B0] * x;
        acc = sat_add(acc, coef[base + TAP_B1] * x1);
        acc = sat_add(acc, coef[base + TAP_B2] * x2);
        acc = sat_add(acc, -(coef[base + TAP_A1] * y1));
        acc = sat_add(acc, -(coef[base + TAP_A2] * y2));
        acc = sat_add(acc, longint'(1) << (QSHIFT - 1));
        acc = acc >>> QSHIFT;
        top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (acc > top) acc = top;
        if (acc < -top - 1) acc = -top - 1;
        return acc;
    endfunction

    // accepted input beat: work out its result and advance history
    function void predict_beat(bit channel, logic signed [SAMPLE_BITS-1:0] sample);
        t_result_beat beat;
        longint       x, mid, y;
        int           k;
        beat.channel = channel;
        if (bypass_on) begin
            beat.sample = sample;
        end else begin
            k   = channel * 2;
            x   = sample;
            mid = run_stage(0, x, in_hist[k], in_hist[k+1], mid_hist[k], mid_hist[k+1]);
            y   = run_stage(TAPS, mid, mid_hist[k], mid_hist[k+1],
                            out_hist[k], out_hist[k+1]);
            in_hist[k+1]  = in_hist[k];
            in_hist[k]    = x;
            mid_hist[k+1] = mid_hist[k];
            mid_hist[k]   = mid;
            out_hist[k+1] = out_hist[k];
            out_hist[k]   = y;
            beat.sample   = y[SAMPLE_BITS-1:0];
        end
        expected_q.push_back(beat);
    endfunction

    // accepted output beat against the oldest expectation
    function void check_beat(bit channel, logic signed [SAMPLE_BITS-1:0] sample);
        t_result_beat want;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: channel_out %0d sample_out %0d",
                   channel, sample);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (channel !== want.channel) begin
            $error("channel_out: expected %0d, got %0d", want.channel, channel);
            errors++;
        end
        if (sample !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, sample);
            errors++;
        end
    endfunction

endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    // leave margin after the last result before touching registers
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_BEATS    = 130;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum {SET_MILD, SET_WILD, SET_EXTREME} t_style;
    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKS} t_rx_mode;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          i_channel   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          i_stall     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx   = '0;
    logic [CFG_BITS-1:0]           i_cfg_data  = '0;
    wire                           o_stall;
    wire                           o_valid;
    wire                           o_channel_out;
    wire signed [SAMPLE_BITS-1:0]  o_sample_out;

    shelf_eq_tracker tracker = new();

    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       quiet_cycles = 0;

    dual_shelf_biquad_cascade dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // receiver: stall pattern switches to a random mode when its run count expires
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   i_stall <= 1'b0;
            RX_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  i_stall <= ($urandom_range(0, 1) == 0);
            default:   i_stall <= ((rx_left % 29) < 11);
        endcase
    end

    // output check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                tracker.check_beat(o_channel_out, o_sample_out);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // present one beat and hold it until accepted
    task automatic send_beat(input bit channel, input logic signed [SAMPLE_BITS-1:0] sample);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_cfg_we    <= 1'b0;
        i_channel   <= channel;
        i_sample_in <= sample;
        do @(posedge i_clk); while (o_stall);
        tracker.predict_beat(channel, sample);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_cfg_we    <= 1'b0;
            i_channel   <= 1'($urandom);
            i_sample_in <= SAMPLE_BITS'($urandom);
        end
    endtask

    // stop sending and wait for every outstanding result plus settle time
    task automatic drain_block();
        @(negedge i_clk);
        i_valid  <= 1'b0;
        i_cfg_we <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high until the next sender action lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.load_reg(idx, data);
    endtask

    task automatic program_filter(input logic [CFG_BITS-1:0] coefs [5], input bit bypass_en);
        logic [CFG_BITS-1:0] byp_word;
        byp_word    = {$urandom, $urandom};
        byp_word[0] = bypass_en;
        write_reg(REG_LOW_B0_B1, coefs[0]);
        write_reg(REG_LOW_B2_A1, coefs[1]);
        write_reg(REG_LOW_A2_HIGH_B0, coefs[2]);
        write_reg(REG_HIGH_B1_B2, coefs[3]);
        write_reg(REG_HIGH_A1_A2, coefs[4]);
        write_reg(REG_BYPASS, byp_word);
    endtask

    // feedback taps get a smaller span so mild settings stay mostly stable
    function automatic logic [COEF_BITS-1:0] pick_coef(t_style style, bit feedback);
        int span;
        span = feedback ? (1 << 27) : (1 << 29);
        case (style)
            SET_MILD: return $urandom_range(0, 2 * span) - span;
            SET_WILD: return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    3:       return COEF_ONE;
                    default: return -COEF_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return SAMPLE_BITS'($urandom_range(0, 4000) - 2000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // random beats in bursts; steady streams skip the sender gaps
    task automatic stream_samples(input int count, input bit steady);
        int sent;
        int burst;
        bit ch;
        sent = 0;
        ch   = 1'($urandom);
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++) begin
                if ($urandom_range(0, 3) == 0) ch = ~ch;
                send_beat(ch, pick_sample());
                sent++;
            end
            if (!steady && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 24));
        end
    endtask

    initial begin
        logic [CFG_BITS-1:0] coefs [5];
        t_style              style;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients are unity on both shelves: samples pass through
        send_beat(0, '0);
        send_beat(1, SAMPLE_MAX);
        send_beat(0, SAMPLE_MIN);
        send_beat(1, -24'sd1);
        send_beat(0, 24'sd1);
        send_beat(1, 24'sh555555);
        send_beat(0, 24'shAAAAAA);
        send_beat(1, SAMPLE_MIN);

        // largest positive coefficients everywhere: output clips
        drain_block();
        coefs = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
        program_filter(coefs, 1'b0);
        send_beat(1, SAMPLE_MAX);
        send_beat(1, SAMPLE_MIN);
        send_beat(1, SAMPLE_MAX);
        send_beat(1, '0);

        // most negative coefficients everywhere
        drain_block();
        coefs = '{default: 64'h8000_0000_8000_0000};
        program_filter(coefs, 1'b0);
        send_beat(0, SAMPLE_MIN);
        send_beat(0, SAMPLE_MAX);
        send_beat(0, SAMPLE_MIN);

        // bypass with spare-index writes: output equals input, history frozen
        drain_block();
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        write_reg(REG_BYPASS, {{(CFG_BITS-1){1'b1}}, 1'b1});
        send_beat(0, SAMPLE_MIN);
        send_beat(1, SAMPLE_MAX);
        send_beat(0, 24'sh123456);
        send_beat(1, '0);

        // bypass off: history resumes from before the bypassed beats
        drain_block();
        write_reg(REG_BYPASS, {{(CFG_BITS-1){1'b1}}, 1'b0});
        send_beat(0, 24'sh000400);
        send_beat(1, -24'sh000400);

        // random phases, each under its own coefficient setting
        for (int phase = 0; phase < 8; phase++) begin
            drain_block();
            case (phase % 4)
                1:       style = SET_WILD;
                3:       style = SET_EXTREME;
                default: style = SET_MILD;
            endcase
            coefs[0] = {pick_coef(style, 0), pick_coef(style, 0)};
            coefs[1] = {pick_coef(style, 0), pick_coef(style, 1)};
            coefs[2] = {pick_coef(style, 1), pick_coef(style, 0)};
            coefs[3] = {pick_coef(style, 0), pick_coef(style, 0)};
            coefs[4] = {pick_coef(style, 1), pick_coef(style, 1)};
            program_filter(coefs, phase == 5);
            stream_samples(PHASE_BEATS, phase == 2 || phase == 6);
        end

        drain_block();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
